// ----- src/rce_pkg.sv -----
// Package for the rANS context encoder: widths, codes, payload types.
// Used by the channel interfaces, the top level and the testbench.
package rce_pkg;

  // Coder geometry
  localparam int LogM    = 12;
  localparam int FreqW   = LogM + 1;
  localparam int CumW    = LogM;
  localparam int StateW  = LogM + 8;
  localparam int EntryW  = FreqW + CumW;
  localparam int SlotW   = 16;
  localparam int TableDepth = 1 << SlotW;
  localparam int QuotW   = 8;
  localparam int DivCntW = $clog2(QuotW);
  localparam int StateBytes = 4;
  localparam int EmitW   = 8 * StateBytes;
  localparam int CntW    = 3;
  localparam int MaxRenorm = 3;
  localparam logic [StateW-1:0] StateInit = StateW'(1 << LogM);

  // Register codes
  localparam logic [1:0] CtxOrderHash  = 2'd2;
  localparam logic [1:0] CtxOrderReset = 2'd1;

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdEncode = 2'd1,
    CmdFinish = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StRenorm,
    StDivide,
    StUpdate,
    StEmit
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  entry_context;
    logic [7:0]  entry_symbol;
    logic [12:0] entry_freq;
    logic [7:0]  symbol;
    logic [7:0]  prev_byte;
    logic [7:0]  prev_prev_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       last;
  } out_item_t;

  // Control strobes from the FSM output decode
  typedef struct packed {
    logic in_ready;
    logic in_accept;
    logic ram_we;
    logic ram_re;
    logic renorm_take;
    logic emit_go;
  } ctrl_t;

endpackage

// ----- src/rce_in_if.sv -----
// Input channel of the rANS context encoder: valid/ready plus command item.
// Depends on rce_pkg for the payload type.
interface rce_in_if
  import rce_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rce_out_if.sv -----
// Output channel of the rANS context encoder: valid/ready plus result item.
// Depends on rce_pkg for the payload type.
interface rce_out_if
  import rce_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rans_context_encoder.sv -----
// rANS encoder with byte renormalization and per-context frequency tables.
// Depends on rce_pkg, rce_in_if, rce_out_if and rce_ram.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+--------------------------------------------
//  in_i      | in  | valid/ready   | command, entry slot/freq, symbol, prev bytes
//  out_o     | out | valid/ready   | out_byte, byte_valid, status, last
//  cfg_we_i  | in  | write strobe  | cfg_wdata_i = context_order
//
// A load transaction writes its table entry and the block stays idle and ready.
// An encode goes through the accept, a table read, renorm checks that take up to
// three bytes, 8 quotient steps (one bit per cycle, restoring divider), a state
// update and one to three results. A zero-frequency symbol goes from the table
// read straight to its error result. A finish gives four result bytes, low first.
// One item is in flight at a time; ready is high only while idle.
// A stalled output holds the result register and the sequencer waits on it.
// Reset clears control state and the coder state; the table RAM is not cleared.
module rans_context_encoder
  import rce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  rce_in_if.sink     in_i,
  rce_out_if.source  out_o
);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [1:0]          ctx_order_q;
  logic [StateW-1:0]   coder_state_q;
  logic [FreqW-1:0]    run_sum_q;
  logic [StateW-1:0]   x_q;
  logic [FreqW-1:0]    fs_q;
  logic [CumW-1:0]     cum_q;
  logic [StateW-1:0]   div_q;
  logic [QuotW-1:0]    quot_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [EmitW-1:0]    emit_q;
  logic [CntW-1:0]     n_q;
  logic                status_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  cmd_e              cmd;
  logic [7:0]        ctx;
  logic [9:0]        hash;
  logic [FreqW-1:0]  load_freq;
  logic [FreqW-1:0]  load_base;
  logic [EntryW-1:0] ram_rdata;
  logic [FreqW-1:0]  rd_freq;
  logic [CumW-1:0]   rd_cum;
  logic [StateW:0]   upper;
  logic              div_ge;
  logic              emit_last;
  logic              slot_free;

  assign cmd = cmd_e'(in_i.data.command);

  // Context select and load-side values
  assign hash      = {in_i.data.prev_prev_byte, 2'b00} + 10'(in_i.data.prev_prev_byte)
                   + 10'(in_i.data.prev_byte);
  assign ctx       = (ctx_order_q == CtxOrderHash) ? hash[7:0] : in_i.data.prev_byte;
  assign load_freq = FreqW'(in_i.data.entry_freq);
  assign load_base = (in_i.data.entry_symbol == 8'd0) ? '0 : run_sum_q;

  // Frequency and cumulative start table
  rce_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_we),
    .waddr_i ({in_i.data.entry_context, in_i.data.entry_symbol}),
    .wdata_i ({load_freq, load_base[CumW-1:0]}),
    .re_i    (ctrl.ram_re),
    .raddr_i ({ctx, in_i.data.symbol}),
    .rdata_o (ram_rdata)
  );

  assign rd_freq = ram_rdata[EntryW-1 -: FreqW];
  assign rd_cum  = ram_rdata[CumW-1:0];

  // Datapath compares
  assign upper     = {fs_q, 8'h00};
  assign div_ge    = (x_q >= div_q);
  assign emit_last = (n_q <= CntW'(1));
  assign slot_free = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (ctrl.in_accept) begin
          unique case (cmd)
            CmdEncode: state_d = StLookup;
            CmdFinish: state_d = StEmit;
            default:   state_d = StIdle;
          endcase
        end
      end
      StLookup: state_d = (rd_freq == '0) ? StEmit : StRenorm;
      StRenorm: begin
        if (!ctrl.renorm_take) begin
          state_d = StDivide;
        end
      end
      StDivide: begin
        if (div_cnt_q == DivCntW'(QuotW - 1)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: state_d = StEmit;
      StEmit: begin
        if (ctrl.emit_go && emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output decode
  always_comb begin
    ctrl.in_ready    = (state_q == StIdle);
    ctrl.in_accept   = ctrl.in_ready && in_i.valid;
    ctrl.ram_we      = ctrl.in_accept && (cmd == CmdLoad);
    ctrl.ram_re      = ctrl.in_accept && (cmd == CmdEncode);
    ctrl.renorm_take = (state_q == StRenorm) && ({1'b0, x_q} >= upper)
                       && (n_q != CntW'(MaxRenorm));
    ctrl.emit_go     = (state_q == StEmit) && slot_free;
  end

  assign in_i.ready  = ctrl.in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      ctx_order_q   <= CtxOrderReset;
      coder_state_q <= StateInit;
      run_sum_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ctx_order_q <= cfg_wdata_i;
      end
      if (ctrl.ram_we) begin
        run_sum_q <= load_base + load_freq;
      end
      if (ctrl.in_accept && (cmd == CmdFinish)) begin
        coder_state_q <= StateInit;
      end else if (state_q == StUpdate) begin
        coder_state_q <= StateW'({quot_q, {LogM{1'b0}}}) + StateW'(cum_q) + x_q;
      end
      if (ctrl.emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: renorm shifter, serial divider, result shifter
  always_ff @(posedge clk_i) begin
    if (ctrl.in_accept) begin
      x_q      <= coder_state_q;
      status_q <= 1'b0;
      if (cmd == CmdFinish) begin
        emit_q <= EmitW'(coder_state_q);
        n_q    <= CntW'(StateBytes);
      end else begin
        n_q    <= '0;
      end
    end
    if (state_q == StLookup) begin
      fs_q     <= rd_freq;
      cum_q    <= rd_cum;
      status_q <= (rd_freq == '0);
    end
    if (ctrl.renorm_take) begin
      emit_q[{n_q[1:0], 3'b000} +: 8] <= x_q[7:0];
      x_q <= x_q >> 8;
      n_q <= n_q + CntW'(1);
    end else if (state_q == StRenorm) begin
      div_q     <= StateW'({fs_q, 7'b0});
      quot_q    <= '0;
      div_cnt_q <= '0;
    end
    if (state_q == StDivide) begin
      if (div_ge) begin
        x_q <= x_q - div_q;
      end
      quot_q    <= {quot_q[QuotW-2:0], div_ge};
      div_q     <= div_q >> 1;
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    if (ctrl.emit_go) begin
      out_data_q.last <= emit_last;
      if (n_q == '0) begin
        out_data_q.out_byte   <= 8'h00;
        out_data_q.byte_valid <= 1'b0;
        out_data_q.status     <= status_q;
      end else begin
        out_data_q.out_byte   <= emit_q[7:0];
        out_data_q.byte_valid <= 1'b1;
        out_data_q.status     <= 1'b0;
        emit_q                <= emit_q >> 8;
        n_q                   <= n_q - CntW'(1);
      end
    end
  end

`ifndef SYNTH
  // Divider input must give a quotient that fits its bits
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> ({1'b0, x_q} < upper))
    else $error("divider operand exceeds quotient range");

  // Zero frequency leaves the coder state alone
  a_zero_freq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup && rd_freq == '0) |=> $stable(coder_state_q))
    else $error("coder state changed on zero frequency");

  // Finish restarts the coder state
  a_finish_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.in_accept && cmd == CmdFinish) |=> (coder_state_q == StateInit))
    else $error("coder state not restarted after finish");

  // The final result of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit_go && emit_last) |=> (state_q == StIdle && out_valid_q && out_data_q.last))
    else $error("last result did not end the item");
`endif

endmodule

// ----- src/rce_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module rce_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the rANS context encoder: random and directed command transactions
// on valid/ready channels, with every result checked against an internal model.
// Depends on rce_pkg, rce_in_if, rce_out_if and rans_context_encoder.
module tb_top;
  import rce_pkg::*;

  // Context order settings that fall back to the previous-byte context
  localparam logic [1:0] CtxOrderPlainLo = 2'd0;
  localparam logic [1:0] CtxOrderPlainHi = 2'd3;
  // Command code with no meaning; the block drops it
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned FreqMax      = 1 << LogM;
  localparam int unsigned InvFive      = 205;   // 5 * 205 == 1 mod 256
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned RandPerPhase = 20;
  // Symbols loaded per random context, 0 up in order
  localparam int unsigned CtxSyms      = 16;

  // Model of the coder: tables, running sum, coder state, queued bytes
  class rans_byte_check;
    logic [FreqW-1:0]  freq_tbl [TableDepth];
    logic [CumW-1:0]   cum_tbl  [TableDepth];
    logic [FreqW-1:0]  run_sum;
    logic [StateW-1:0] coder_x;
    logic [1:0]        ctx_order;
    out_item_t         coded_bytes_q [$];
    int                errors;

    function new();
      run_sum   = '0;
      coder_x   = StateInit;
      ctx_order = CtxOrderReset;
      errors    = 0;
    endfunction

    function void set_order(logic [1:0] value);
      ctx_order = value;
    endfunction

    function int pending();
      return coded_bytes_q.size();
    endfunction

    // Queue one expected result at the tail
    function void add_expected(out_item_t b);
      coded_bytes_q = {coded_bytes_q, b};
    endfunction

    // Work out the bytes that one accepted command produces
    function void note_command(in_item_t it);
      logic [SlotW-1:0] slot;
      logic [7:0]       ctx;
      logic [FreqW-1:0] base;
      int unsigned      fs;
      int unsigned      x;
      int unsigned      n;
      case (it.command)
        CmdLoad: begin
          slot           = {it.entry_context, it.entry_symbol};
          base           = (it.entry_symbol == 8'd0) ? '0 : run_sum;
          freq_tbl[slot] = it.entry_freq;
          cum_tbl[slot]  = base[CumW-1:0];
          run_sum        = base + it.entry_freq;
        end
        CmdEncode: begin
          ctx  = (ctx_order == CtxOrderHash) ?
                 8'(it.prev_prev_byte * 8'd5 + it.prev_byte) : it.prev_byte;
          slot = {ctx, it.symbol};
          fs   = freq_tbl[slot];
          if (fs == 0) begin
            // zero frequency: error status, state untouched
            add_expected('{8'h00, 1'b0, 1'b1, 1'b1});
          end else begin
            x = coder_x;
            n = 0;
            while (x >= (fs << 8) && n < MaxRenorm) begin
              add_expected('{8'(x), 1'b1, 1'b0, 1'b0});
              x = x >> 8;
              n++;
            end
            coder_x = StateW'((x / fs) * FreqMax + cum_tbl[slot] + (x % fs));
            if (n == 0) begin
              add_expected('{8'h00, 1'b0, 1'b0, 1'b1});
            end else begin
              coded_bytes_q[coded_bytes_q.size() - 1].last = 1'b1;
            end
          end
        end
        CmdFinish: begin
          // state goes out low byte first, then the coder restarts
          for (int k = 0; k < StateBytes; k++) begin
            add_expected('{8'(coder_x >> (8 * k)), 1'b1, 1'b0,
                           1'(k == StateBytes - 1)});
          end
          coder_x = StateInit;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest expected byte
    function void check_byte(out_item_t got);
      out_item_t want;
      if (coded_bytes_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h valid %0b",
                 $time, got.out_byte, got.byte_valid);
        $display("%0t:   status %0b last %0b", $time, got.status, got.last);
        errors++;
        return;
      end
      want = coded_bytes_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  int unsigned src_idle_pct = 7;
  int unsigned sink_idle_pct = 65;
  logic        out_hold = 1'b0;
  bit          pressure_go = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned full_ctx_q [$];
  rans_byte_check byte_chk;

  rce_in_if  in_ch ();
  rce_out_if out_ch ();

  rans_context_encoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #6 clk = ~clk;

  // Result side: random back-pressure, blocked entirely during a hold-off
  always @(posedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    out_hold <= 1'b0;
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      byte_chk.check_byte(out_ch.data);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("rans_context_encoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t rand_fill();
    logic [63:0] r;
    in_item_t    it;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.entry_freq = 13'($urandom_range(FreqMax));
    return it;
  endfunction

  // Offer one command; valid stays up until the transaction is taken
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    byte_chk.note_command(it);
  endtask

  task automatic send_load(int unsigned ctx, int unsigned sym, int unsigned freq);
    in_item_t it;
    it = rand_fill();
    it.command       = CmdLoad;
    it.entry_context = 8'(ctx);
    it.entry_symbol  = 8'(sym);
    it.entry_freq    = 13'(freq);
    send_item(it);
  endtask

  task automatic send_encode(int unsigned sym, int unsigned p1, int unsigned p2);
    in_item_t it;
    it = rand_fill();
    it.command        = CmdEncode;
    it.symbol         = 8'(sym);
    it.prev_byte      = 8'(p1);
    it.prev_prev_byte = 8'(p2);
    send_item(it);
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    in_item_t it;
    it = rand_fill();
    it.command = cmd;
    send_item(it);
  endtask

  // Wait until every expected byte is out, then let the sequencer settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (byte_chk.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_order(logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    byte_chk.set_order(value);
  endtask

  // Table for one context: symbols 0..CtxSyms-1 in order, summing to M
  task automatic load_context(int unsigned ctx);
    int unsigned share [CtxSyms];
    int unsigned left;
    int unsigned cap;
    int unsigned c;
    foreach (share[i]) share[i] = 0;
    left = FreqMax;
    while (left != 0) begin
      cap = $urandom_range(1) ? 16 : 900;
      c = $urandom_range((left < cap) ? left : cap, 1);
      share[$urandom_range(CtxSyms - 1)] += c;
      left -= c;
    end
    for (int i = 0; i < CtxSyms; i++) send_load(ctx, i, share[i]);
    full_ctx_q = {full_ctx_q, ctx};
  endtask

  // Mostly encodes on loaded contexts, some finishes and stray loads
  task automatic random_item();
    int unsigned roll;
    int unsigned ctx;
    int unsigned sym;
    int unsigned p1;
    int unsigned p2;
    int unsigned tries;
    roll = $urandom_range(99);
    if (roll < 10) begin
      send_load($urandom_range(255), $urandom_range(255), $urandom_range(FreqMax));
    end else if (roll < 18) begin
      send_cmd(CmdFinish);
    end else begin
      ctx   = full_ctx_q[$urandom_range(full_ctx_q.size() - 1)];
      sym   = $urandom_range(CtxSyms - 1);
      tries = 0;
      // usually steer to a symbol that has a frequency
      while (roll < 95 && tries < 40 && byte_chk.freq_tbl[{8'(ctx), 8'(sym)}] == 0) begin
        sym = $urandom_range(CtxSyms - 1);
        tries++;
      end
      p1 = $urandom_range(255);
      p2 = $urandom_range(255);
      if (byte_chk.ctx_order == CtxOrderHash) begin
        p2 = ((ctx - p1) * InvFive) & 8'hFF;
      end else begin
        p1 = ctx;
      end
      send_encode(sym, p1, p2);
    end
  endtask

  initial begin
    int unsigned ctx;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = CtxOrderReset;
    byte_chk     = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme frequencies, zero frequency, one and two
    // renormalization bytes, wrapped running sum, finish, unused code
    send_load(8'hFF, 8'h00, FreqMax);
    send_load(8'hFF, 8'h01, 0);
    send_load(8'hFF, 8'h02, 1);
    send_load(8'hFF, 8'hFF, FreqMax);
    send_load(8'h00, 8'h00, 1);
    send_load(8'h00, 8'h01, FreqMax - 1);
    send_encode(8'h00, 8'hFF, 8'h00);
    send_encode(8'h01, 8'hFF, 8'hFF);
    send_encode(8'h02, 8'hFF, 8'h00);
    send_encode(8'h02, 8'hFF, 8'hFF);
    send_encode(8'hFF, 8'hFF, 8'h00);
    send_encode(8'h00, 8'h00, 8'hFF);
    send_encode(8'h01, 8'h00, 8'h00);
    send_cmd(CmdFinish);
    send_cmd(CmdUnused);
    send_encode(8'h02, 8'hFF, 8'h55);
    send_encode(8'h02, 8'hFF, 8'hAA);
    send_encode(8'h01, 8'h00, 8'h00);
    send_cmd(CmdFinish);

    // Random phases, each with its own context order; the first three set their own idle pattern
    for (int seg = 0; seg < 4; seg++) begin
      drain();
      case (seg)
        0: begin
          src_idle_pct = 7;
          sink_idle_pct <= 65;
          write_order(CtxOrderHash);
        end
        1: begin
          src_idle_pct = 65;
          sink_idle_pct <= 7;
          write_order(CtxOrderPlainLo);
        end
        2: begin
          src_idle_pct = 0;
          sink_idle_pct <= 0;
          write_order(CtxOrderPlainHi);
        end
        default: begin
          write_order(CtxOrderReset);
        end
      endcase
      if (seg == 0 || seg == 2) begin
        do ctx = $urandom_range(254, 1); while (ctx inside {full_ctx_q});
        load_context(ctx);
      end
      if (seg == 2) pressure_go = 1'b1;
      repeat (RandPerPhase) random_item();
    end

    drain();
    if (byte_chk.errors == 0) begin
      $display("rans_context_encoder test passed");
    end else begin
      $display("rans_context_encoder test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rce_pkg.sv
src/rce_in_if.sv
src/rce_out_if.sv
src/rce_ram.sv
src/rans_context_encoder.sv
sim/tb_top.sv
